FILE: rtl/cross_median_filter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cross median filter
// Shared concurrent checks, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef CROSS_MEDIAN_FILTER_TOP_MACROS_SVH
`define CROSS_MEDIAN_FILTER_TOP_MACROS_SVH

// Property must hold at every edge out of reset
`define CMF_ASSERT_HOLDS(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cross median filter: invariant violated");

// Antecedent at one edge implies consequent at the next edge
`define CMF_ASSERT_THEN(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cross median filter: sequence violated");

`endif

FILE: rtl/cmf_pkg.sv
// ----------------------------------------------------------------------------
// cmf_pkg
// Types, constants and the five-input median for the cross median filter.
// ----------------------------------------------------------------------------
package cmf_pkg;

    // Geometry and sample width
    localparam int MAX_WIDTH  = 1024;
    localparam int PIXEL_BITS = 16;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int EW_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int WCFG_BITS  = 11;
    localparam int HGT_BITS   = 16;
    localparam int ROW_BITS   = HGT_BITS + 1;

    // Configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int RESET_EW     = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    // Item modes
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // Result queue
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [COL_BITS-1:0]   col_t;
    typedef logic [ROW_BITS-1:0]   row_t;

    // One line-store word: the two previous rows at one column
    typedef struct packed {
        pixel_t up;
        pixel_t mid;
    } line_pair_t;

    // Item waiting for its line-store read data
    typedef struct packed {
        col_t   col;
        pixel_t pix;
        logic   have;
        logic   med;
        logic   last;
    } s1_ctrl_t;

    // Cross neighborhood ready for selection
    typedef struct packed {
        pixel_t ctr;
        pixel_t up;
        pixel_t down;
        pixel_t left;
        pixel_t right;
        logic   med;
        logic   last;
    } s2_item_t;

    typedef struct packed {
        pixel_t pixel;
        logic   last;
    } out_item_t;

    // Median of five by rank: ties broken by position so one rank is exactly 2
    function automatic pixel_t median5(input pixel_t a, input pixel_t b, input pixel_t c,
                                       input pixel_t d, input pixel_t e);
        pixel_t     v [5];
        logic [2:0] rank;
        pixel_t     res;
        v[0] = a;
        v[1] = b;
        v[2] = c;
        v[3] = d;
        v[4] = e;
        res  = '0;
        for (int i = 0; i < 5; i++)
        begin
            rank = '0;
            for (int j = 0; j < 5; j++)
            begin
                if (j != i && (v[j] < v[i] || (v[j] == v[i] && j < i)))
                begin
                    rank = rank + 3'd1;
                end
            end
            if (rank == 3'd2)
            begin
                res = v[i];
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/cmf_ifs.sv
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface cmf_sample_if;
    import cmf_pkg::*;
    logic   valid;
    logic   ready;
    logic   mode;
    pixel_t pixel_in;

    modport source (output valid, output mode, output pixel_in, input ready);
    modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface cmf_result_if;
    import cmf_pkg::*;
    logic   valid;
    logic   ready;
    pixel_t pixel_out;
    logic   frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface cmf_cfg_if;
    import cmf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/cmf_ram.sv
// ----------------------------------------------------------------------------
// cmf_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/cross_median_filter_top.sv
// ----------------------------------------------------------------------------
// cross_median_filter_top
// Five-point cross median over a raster image stream, two rows held in a
// line-store RAM, borders passed through unchanged.
// ----------------------------------------------------------------------------
//  channel    | dir | payload                 | accepted when
//  sample_ch  | in  | mode, pixel_in          | valid && ready
//  result_ch  | out | pixel_out, frame_last   | valid && ready
//  cfg_ch     | in  | index, data             | valid && ready (always ready)
//
//  One item per clock while sample_ch.ready is high. A result is registered
//  in the line-store read stage, then the median stage, then the result queue.
//  The line store is not cleared at reset; unwritten reads never reach a result.
//  sample_ch.ready drops when queued results plus items in flight reach four.
// ----------------------------------------------------------------------------
`include "cross_median_filter_top_macros.svh"

module cross_median_filter_top (
    input logic         clk,
    input logic         rst_n,
    cmf_sample_if.sink  sample_ch,
    cmf_result_if.source result_ch,
    cmf_cfg_if.sink     cfg_ch
);
    import cmf_pkg::*;

    // Configuration
    logic [EW_BITS-1:0]   ew_reg;
    logic [HGT_BITS-1:0]  eh_reg;
    logic                 cfg_wr;
    logic [WCFG_BITS-1:0] raw_w;
    logic [HGT_BITS-1:0]  raw_h;

    // Input position
    col_t               col_reg, col_next;
    row_t               row_reg, row_next;
    logic               in_take, drain, s0_act, s0_have, s0_med, s0_last;
    logic               col_nz, row_ge2, col_wrap;
    logic [EW_BITS-1:0] col_inc;

    // Line-store read stage
    s1_ctrl_t   s1_reg;
    logic       s1_valid_reg;
    logic       fwd_reg;
    line_pair_t fwd_data_reg;
    line_pair_t ram_rdata, rd_pair, wr_pair;

    // Window of the row above the input row
    pixel_t win_up_reg, win_ctr_reg, win_left_reg, down_reg;

    // Selection stage
    s2_item_t s2_reg;
    logic     s2_valid_reg;
    pixel_t   s2_val;

    // Result queue
    out_item_t                oq_mem [OQ_DEPTH];
    logic [OQ_PTR_BITS-1:0]   oq_wr_reg, oq_rd_reg;
    logic [OQ_CNT_BITS-1:0]   oq_cnt_reg, oq_cnt_next;
    logic [OQ_CNT_BITS:0]     inflight_cnt;
    logic                     oq_push, oq_pop;

    // ---------------- configuration ----------------
    assign cfg_ch.ready = 1'b1;
    assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
    assign raw_w        = cfg_ch.data[WCFG_BITS-1:0];
    assign raw_h        = cfg_ch.data[HGT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ew_reg <= EW_BITS'(RESET_EW);
            eh_reg <= HGT_BITS'(RESET_HEIGHT);
        end
        else if (cfg_wr)
        begin
            if (cfg_ch.index == REG_IMAGE_WIDTH)
            begin
                // zero reads as one, above capacity reads as capacity
                if (raw_w == '0)
                begin
                    ew_reg <= EW_BITS'(1);
                end
                else if (32'(raw_w) > MAX_WIDTH)
                begin
                    ew_reg <= EW_BITS'(MAX_WIDTH);
                end
                else
                begin
                    ew_reg <= EW_BITS'(raw_w);
                end
            end
            else if (cfg_ch.index == REG_IMAGE_HEIGHT)
            begin
                eh_reg <= (raw_h == '0) ? HGT_BITS'(1) : raw_h;
            end
        end
    end

    // ---------------- input position and classification ----------------
    assign inflight_cnt = (OQ_CNT_BITS+1)'(oq_cnt_reg) + (OQ_CNT_BITS+1)'(s1_valid_reg)
                        + (OQ_CNT_BITS+1)'(s2_valid_reg);
    assign sample_ch.ready = inflight_cnt < (OQ_CNT_BITS+1)'(OQ_DEPTH);
    assign in_take = sample_ch.valid && sample_ch.ready;

    // rows past the frame height are drain rows; sample values are dropped there
    assign drain   = row_reg >= ROW_BITS'(eh_reg);
    assign s0_act  = in_take && (drain || sample_ch.mode == MODE_PIXEL);
    assign col_nz  = col_reg != '0;
    assign row_ge2 = row_reg >= ROW_BITS'(2);
    assign s0_have = (col_nz && row_reg != '0) || (!col_nz && row_ge2);
    assign s0_med  = col_reg >= COL_BITS'(2) && row_ge2 && !drain;
    // final pixel of the frame is the right edge, emitted at column zero two rows on
    assign s0_last = !col_nz && row_reg == ROW_BITS'(eh_reg) + ROW_BITS'(1);
    assign col_inc  = EW_BITS'(col_reg) + EW_BITS'(1);
    assign col_wrap = col_inc == ew_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (cfg_wr || (s0_act && s0_last))
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (s0_act && col_wrap)
        begin
            col_next = '0;
            row_next = row_reg + ROW_BITS'(1);
        end
        else if (s0_act)
        begin
            col_next = col_inc[COL_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line store ----------------
    cmf_ram #(
        .WIDTH ($bits(line_pair_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_reg.col),
        .wdata (wr_pair),
        .rd_en (s0_act),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // forward the write of the item ahead when it hits the same column
    assign rd_pair     = fwd_reg ? fwd_data_reg : ram_rdata;
    assign wr_pair.up  = rd_pair.mid;
    assign wr_pair.mid = s1_reg.pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_act;
            fwd_reg      <= s0_act && s1_valid_reg && col_reg == s1_reg.col;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_pair;
        if (s0_act)
        begin
            s1_reg.col  <= col_reg;
            s1_reg.pix  <= drain ? '0 : sample_ch.pixel_in;
            s1_reg.have <= s0_have;
            s1_reg.med  <= s0_med;
            s1_reg.last <= s0_last;
        end
    end

    // ---------------- window and neighborhood capture ----------------
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            win_left_reg <= win_ctr_reg;
            win_ctr_reg  <= rd_pair.mid;
            win_up_reg   <= rd_pair.up;
            down_reg     <= s1_reg.pix;
            s2_reg.ctr   <= win_ctr_reg;
            s2_reg.up    <= win_up_reg;
            s2_reg.down  <= down_reg;
            s2_reg.left  <= win_left_reg;
            s2_reg.right <= rd_pair.mid;
            s2_reg.med   <= s1_reg.med;
            s2_reg.last  <= s1_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg && s1_reg.have;
        end
    end

    // ---------------- median select ----------------
    assign s2_val = s2_reg.med
                  ? median5(s2_reg.ctr, s2_reg.right, s2_reg.left, s2_reg.up, s2_reg.down)
                  : s2_reg.ctr;

    // ---------------- result queue ----------------
    assign oq_push = s2_valid_reg;
    assign oq_pop  = result_ch.valid && result_ch.ready;

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        unique case ({oq_push, oq_pop})
            2'b10:   oq_cnt_next = oq_cnt_reg + OQ_CNT_BITS'(1);
            2'b01:   oq_cnt_next = oq_cnt_reg - OQ_CNT_BITS'(1);
            default: oq_cnt_next = oq_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            oq_cnt_reg <= oq_cnt_next;
            if (oq_push)
            begin
                oq_wr_reg <= oq_wr_reg + OQ_PTR_BITS'(1);
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + OQ_PTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem[oq_wr_reg].pixel <= s2_val;
            oq_mem[oq_wr_reg].last  <= s2_reg.last;
        end
    end

    assign result_ch.valid      = oq_cnt_reg != '0;
    assign result_ch.pixel_out  = oq_mem[oq_rd_reg].pixel;
    assign result_ch.frame_last = oq_mem[oq_rd_reg].last;

    // ---------------- checks ----------------
    `CMF_ASSERT_HOLDS(a_credit_bound, clk, rst_n, inflight_cnt <= (OQ_CNT_BITS+1)'(OQ_DEPTH))
    `CMF_ASSERT_THEN(a_frame_restart, clk, rst_n, s0_act && s0_last, col_reg == '0 && row_reg == '0)
    `CMF_ASSERT_HOLDS(a_fwd_same_col, clk, rst_n, !fwd_reg || (s1_valid_reg && s1_reg.col == $past(s1_reg.col)))
    `CMF_ASSERT_HOLDS(a_push_room, clk, rst_n, !oq_push || oq_pop || oq_cnt_reg < OQ_CNT_BITS'(OQ_DEPTH))

endmodule

FILE: dv/cross_median_filter_top_tb.sv
// ----------------------------------------------------------------------------
// cross_median_filter_top_tb
// Streams raster frames of many sizes through the cross median filter and
// checks each filtered pixel and its frame_last flag against a cycle-free
// predictor. The sender and the receiver stall at random. Register writes
// happen only while the filter is idle.
// ----------------------------------------------------------------------------
module cross_median_filter_top_tb;
    import cmf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 330;

    typedef struct packed {
        logic   mode;
        pixel_t pix;
        logic   hold;
    } sample_item_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Testbench-side drivers of the channels, known from time zero
    logic                     smp_valid = 1'b0;
    logic                     smp_mode  = MODE_PIXEL;
    pixel_t                   smp_pixel = '0;
    logic                     res_ready = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    cmf_sample_if sample_ch ();
    cmf_result_if result_ch ();
    cmf_cfg_if    cfg_ch ();

    assign sample_ch.valid    = smp_valid;
    assign sample_ch.mode     = smp_mode;
    assign sample_ch.pixel_in = smp_pixel;
    assign result_ch.ready    = res_ready;
    assign cfg_ch.valid       = cfg_valid;
    assign cfg_ch.index       = cfg_index;
    assign cfg_ch.data        = cfg_data;

    cross_median_filter_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_ch    (cfg_ch)
    );

    // Stimulus and scoreboard storage
    sample_item_t pending_samples [$];
    out_item_t    expected_pixels [$];
    int unsigned  items_issued   = 0;
    int unsigned  items_taken    = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  idle_cycles    = 0;
    logic         sample_fired   = 1'b0;
    logic         result_fired   = 1'b0;
    logic         cfg_fired      = 1'b0;
    int           send_gap       = 0;
    int           send_calm      = 0;
    int           recv_stall     = 0;
    int           recv_calm      = 0;

    // Predictor state: two previous rows, the 3-tap window, positions
    logic [WCFG_BITS-1:0] pred_width  = 11'(RESET_WIDTH);
    logic [HGT_BITS-1:0]  pred_height = 16'(RESET_HEIGHT);
    pixel_t               older_row [MAX_WIDTH];
    pixel_t               newer_row [MAX_WIDTH];
    pixel_t               win_up    = '0;
    pixel_t               win_ctr   = '0;
    pixel_t               win_left  = '0;
    int unsigned          next_col  = 0;
    int unsigned          next_row  = 0;
    int unsigned          next_out  = 0;

    initial
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic pixel_t median_of_five(input pixel_t a, b, c, d, e);
        pixel_t s [5];
        pixel_t t;
        int     j;
        s[0] = a;
        s[1] = b;
        s[2] = c;
        s[3] = d;
        s[4] = e;
        for (int i = 1; i < 5; i++)
        begin
            t = s[i];
            j = i;
            while (j > 0 && s[j-1] > t)
            begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = t;
        end
        return s[2];
    endfunction

    function automatic void restart_frame_state();
        next_col = 0;
        next_row = 0;
        next_out = 0;
        win_up   = '0;
        win_ctr  = '0;
        win_left = '0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                           input logic [CFG_DATA_BITS-1:0] value);
        if (idx == REG_IMAGE_WIDTH)
        begin
            pred_width = value[WCFG_BITS-1:0];
        end
        else if (idx == REG_IMAGE_HEIGHT)
        begin
            pred_height = value[HGT_BITS-1:0];
        end
        restart_frame_state();
    endfunction

    // One accepted item: update the window and queue the pixel it completes
    function automatic void cross_median_step(input logic mode, input pixel_t pix);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        pixel_t      old_up;
        pixel_t      old_mid;
        pixel_t      val;
        logic        have;
        logic        draining;
        out_item_t   res;
        w = (pred_width == 0) ? 1 : ((pred_width > MAX_WIDTH) ? MAX_WIDTH : pred_width);
        h = (pred_height == 0) ? 1 : pred_height;
        draining = (next_row >= h);
        // early drain: nothing happens
        if (!draining && mode == MODE_DRAIN)
        begin
            return;
        end
        // late sample acts as a drain
        if (draining)
        begin
            pix = '0;
        end
        c = (next_col >= w) ? 0 : next_col;
        r = next_row;
        old_up  = older_row[c];
        old_mid = newer_row[c];
        have = 1'b0;
        val  = '0;
        if (c >= 1 && r >= 1)
        begin
            have = 1'b1;
            val  = win_ctr;
            // interior pixel at row r-1, column c-1
            if (w >= 3 && h >= 3 && r >= 2 && r + 1 <= h && c >= 2 && c + 1 <= w)
            begin
                val = median_of_five(win_ctr, old_mid, win_left, win_up, newer_row[c-1]);
            end
        end
        else if (c == 0 && r >= 2)
        begin
            // last column of the row two back
            have = 1'b1;
            val  = older_row[w-1];
        end
        win_left     = win_ctr;
        win_ctr      = old_mid;
        win_up       = old_up;
        older_row[c] = old_mid;
        newer_row[c] = pix;
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        next_col = c;
        next_row = r;
        if (have)
        begin
            res.pixel = val;
            res.last  = (next_out == w * h - 1);
            expected_pixels = {expected_pixels, res};
            next_out = (next_out + 1) & 32'h03FF_FFFF;
            if (res.last)
            begin
                restart_frame_state();
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    // Idle cycles before the next transaction; occasional stretches with none
    task automatic draw_wait(inout int calm, output int cycles);
        if (calm > 0)
        begin
            calm--;
            cycles = 0;
        end
        else
        begin
            cycles = $urandom_range(0, 6);
            if ($urandom_range(0, 19) == 0)
            begin
                calm = $urandom_range(8, 40);
            end
        end
    endtask

    function automatic void queue_item(input logic mode, input pixel_t pix, input logic hold);
        sample_item_t itm;
        itm.mode = mode;
        itm.pix  = pix;
        itm.hold = hold;
        pending_samples = {pending_samples, itm};
        items_issued++;
    endfunction

    // Every item taken, every result in, then let the pipeline settle
    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (items_taken != items_issued || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
        end
        while (!cfg_fired);
        cfg_valid <= 1'b0;
    endtask

    // Configure, then one whole frame plus the flush; hold_at marks a pause
    task automatic run_frame(input logic [CFG_DATA_BITS-1:0] width_word,
                             input logic [CFG_DATA_BITS-1:0] height_word,
                             input int hold_at, input bit narrow_range);
        int unsigned w;
        int unsigned h;
        pixel_t      pix;
        wait_idle();
        if ($urandom_range(0, 1) == 0)
        begin
            write_reg(REG_IMAGE_WIDTH, width_word);
            write_reg(REG_IMAGE_HEIGHT, height_word);
        end
        else
        begin
            write_reg(REG_IMAGE_HEIGHT, height_word);
            write_reg(REG_IMAGE_WIDTH, width_word);
        end
        w = width_word[WCFG_BITS-1:0];
        w = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
        h = (height_word == 0) ? 1 : height_word;
        for (int k = 0; k < w * h; k++)
        begin
            // stray drain inside the frame is ignored
            if ($urandom_range(0, 15) == 0)
            begin
                queue_item(MODE_DRAIN, pixel_t'($urandom), 1'b0);
            end
            pix = narrow_range ? pixel_t'($urandom_range(0, 3)) : pixel_t'($urandom);
            queue_item(MODE_PIXEL, pix, k == hold_at);
        end
        // flush: a mix of drains and late samples
        for (int k = 0; k <= w; k++)
        begin
            queue_item(logic'($urandom_range(0, 1)), pixel_t'($urandom), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sample driver: launches queued items at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_samples
        sample_item_t nxt;
        logic         load;
        if (rst_n)
        begin
            load = 1'b0;
            if (!smp_valid || sample_fired)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_samples.size() != 0 &&
                         !(pending_samples[0].hold && expected_pixels.size() != 0))
                begin
                    load = 1'b1;
                end
            end
            if (load)
            begin
                nxt = pending_samples.pop_front();
                smp_mode  <= nxt.mode;
                smp_pixel <= nxt.pix;
                draw_wait(send_calm, send_gap);
            end
            smp_valid <= load || (smp_valid && !sample_fired);
        end
    end

    // Result ready: may stall after each accepted result
    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (result_fired)
            begin
                draw_wait(recv_calm, recv_stall);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks results, feeds the predictor, runs the watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_channels
        out_item_t want;
        if (rst_n)
        begin
            result_fired = result_ch.valid && res_ready;
            sample_fired = smp_valid && sample_ch.ready;
            cfg_fired    = cfg_valid && cfg_ch.ready;

            // results belong to earlier items, so check before predicting
            if (result_fired)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result pixel=%h last=%b",
                                              result_ch.pixel_out, result_ch.frame_last));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (result_ch.pixel_out !== want.pixel)
                    begin
                        report_mismatch($sformatf("pixel_out got %h want %h",
                                                  result_ch.pixel_out, want.pixel));
                    end
                    if (result_ch.frame_last !== want.last)
                    begin
                        report_mismatch($sformatf("frame_last got %b want %b",
                                                  result_ch.frame_last, want.last));
                    end
                end
            end

            if (sample_fired)
            begin
                items_taken++;
                cross_median_step(smp_mode, smp_pixel);
            end

            if (cfg_fired)
            begin
                apply_register(cfg_index, cfg_data);
            end

            if (result_fired || sample_fired || cfg_fired)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : sequence_main
        pixel_t               extreme_vals [9];
        int unsigned          w;
        int unsigned          h;
        int unsigned          random_items;
        logic [CFG_DATA_BITS-1:0] width_word;
        bit                   first;

        extreme_vals = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                         16'hFFFE, 16'hFFFF, 16'h0000, 16'hFFFF};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 3x3 frame of extreme samples, early drain first, late sample in flush
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        queue_item(MODE_DRAIN, 16'hFFFF, 1'b0);
        for (int i = 0; i < 9; i++)
        begin
            queue_item(MODE_PIXEL, extreme_vals[i], 1'b0);
        end
        queue_item(MODE_PIXEL, 16'hFFFF, 1'b0);
        repeat (3) queue_item(MODE_DRAIN, 16'h0000, 1'b0);

        // partial 4x4 frame, dropped by the next register write
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 16'd4);
        write_reg(REG_IMAGE_HEIGHT, 16'd4);
        for (int i = 0; i < 6; i++)
        begin
            queue_item(MODE_PIXEL, pixel_t'($urandom), 1'b0);
        end

        // small size corners, incl. junk upper width bits and zero sizes
        run_frame(16'h0000, 16'h0000, -1, 1'b0);
        run_frame(16'hF802, 16'd1, -1, 1'b1);
        run_frame(16'd1, 16'd1, -1, 1'b0);
        run_frame(16'd1, 16'd24, 12, 1'b0);
        run_frame(16'd3, 16'd2, -1, 1'b0);

        // random small frames
        random_items = 0;
        first        = 1'b1;
        while (random_items < RANDOM_ITEMS)
        begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = (w <= 12 && $urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
                                                       : $urandom_range(1, 8);
            width_word = CFG_DATA_BITS'($urandom);
            width_word[WCFG_BITS-1:0] = WCFG_BITS'(w);
            run_frame(width_word, CFG_DATA_BITS'(h), first ? int'(w * h / 2) : -1,
                      $urandom_range(0, 3) == 0);
            random_items += w * h + w + 1;
            first = 1'b0;
        end

        // everything in, then watch for stray results
        wait_idle();
        repeat (2 * SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
